### src/cpseg_pkg.sv
package cpseg_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_W  = 32;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int ROOT_W   = COORD_W + 1;
    localparam int SREM_W   = ROOT_W + 1;
    localparam int QUO_W    = COORD_W + 3;

    // stream widths
    localparam int IN_W     = 9 * COORD_W;
    localparam int OUT_RAW  = 3 * COORD_W + 2 * ROOT_W;
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;

    // unit and total latencies
    localparam int SQ_LAT    = ROOT_W;
    localparam int DIV_LAT   = QUO_W;
    localparam int LAT_TOTAL = 3 + SQ_LAT + DIV_LAT + 2 + DIV_LAT + 3 + SQ_LAT + 1;

endpackage

### src/closest_point_on_segment_unit.sv
// throughput: one request per cycle while the output is not stalled; the rate is set
// by the fully pipelined square root and divider units, one result bit per stage
// a stall on the output holds the whole pipeline in place
// reset clears the valid bits only; data registers are not reset
module closest_point_on_segment_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, query_x, query_y, query_z
    input  logic [cpseg_pkg::IN_W-1:0]   i_s_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // position_along, nearest_x, nearest_y, nearest_z, gap_length, zero pad
    output logic [cpseg_pkg::OUT_W-1:0]  o_m_tdata
);
    import cpseg_pkg::*;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] s;
        logic [2:0][COORD_W-1:0] q;
        logic [2:0]              dneg;
        logic [2:0][DIFF_W-1:0]  dmag;
    } t_geom;

    typedef struct packed {
        logic [PROD_W-1:0] num;
        t_geom             geom;
    } t_dly_d;

    typedef struct packed {
        logic [ROOT_W-1:0] len;
        t_geom             geom;
    } t_dly_e;

    typedef struct packed {
        logic [ROOT_W-1:0]       p;
        logic [2:0][COORD_W-1:0] s;
        logic [2:0][COORD_W-1:0] q;
        logic [2:0]              dneg;
    } t_dly_h;

    typedef struct packed {
        logic [ROOT_W-1:0]       p;
        logic [2:0][COORD_W-1:0] nr;
    } t_tail;

    logic                   w_en;
    logic [LAT_TOTAL-1:0]   r_vld;

    // global advance: the pipeline moves when the output slot is free or taken
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[LAT_TOTAL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT_TOTAL-2:0], i_s_tvalid};
        end
    end

    // stage 1: differences
    logic [2:0][COORD_W-1:0] r1_s, r1_q;
    logic [2:0][DIFF_W-1:0]  r1_d, r1_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_s[i] <= i_s_tdata[i*COORD_W +: COORD_W];
                r1_q[i] <= i_s_tdata[(6+i)*COORD_W +: COORD_W];
                r1_d[i] <= {i_s_tdata[(4+i)*COORD_W-1], i_s_tdata[(3+i)*COORD_W +: COORD_W]}
                         - {i_s_tdata[(1+i)*COORD_W-1], i_s_tdata[i*COORD_W +: COORD_W]};
                r1_v[i] <= {i_s_tdata[(7+i)*COORD_W-1], i_s_tdata[(6+i)*COORD_W +: COORD_W]}
                         - {i_s_tdata[(1+i)*COORD_W-1], i_s_tdata[i*COORD_W +: COORD_W]};
            end
        end
    end

    // stage 2: magnitudes and products
    logic [2:0][DIFF_W-1:0] w2_dmag, w2_vmag;
    t_geom                  r2_geom;
    logic [2:0][PROD_W-1:0] r2_dd, r2_dv;
    logic [2:0]             r2_dvneg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w2_dmag[i] = r1_d[i][DIFF_W-1] ? DIFF_W'(-r1_d[i]) : r1_d[i];
            w2_vmag[i] = r1_v[i][DIFF_W-1] ? DIFF_W'(-r1_v[i]) : r1_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_geom.s <= r1_s;
            r2_geom.q <= r1_q;
            for (int i = 0; i < 3; i++) begin
                r2_geom.dneg[i] <= r1_d[i][DIFF_W-1];
                r2_geom.dmag[i] <= w2_dmag[i];
                r2_dd[i]        <= PROD_W'(w2_dmag[i]) * PROD_W'(w2_dmag[i]);
                r2_dv[i]        <= PROD_W'(w2_dmag[i]) * PROD_W'(w2_vmag[i]);
                r2_dvneg[i]     <= r1_d[i][DIFF_W-1] != r1_v[i][DIFF_W-1];
            end
        end
    end

    // stage 3: squared length and split dot product
    t_geom             r3_geom;
    logic [PROD_W-1:0] r3_l2, r3_pos, r3_neg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_geom <= r2_geom;
            r3_l2   <= r2_dd[0] + r2_dd[1] + r2_dd[2];
            r3_pos  <= (r2_dvneg[0] ? '0 : r2_dv[0]) + (r2_dvneg[1] ? '0 : r2_dv[1])
                     + (r2_dvneg[2] ? '0 : r2_dv[2]);
            r3_neg  <= (r2_dvneg[0] ? r2_dv[0] : '0) + (r2_dvneg[1] ? r2_dv[1] : '0)
                     + (r2_dvneg[2] ? r2_dv[2] : '0);
        end
    end

    // segment length root, dot product waits alongside
    logic [ROOT_W-1:0] w_len;
    t_dly_d            w_d_in;
    t_dly_d            r_dly_d [SQ_LAT];

    cpseg_sqrt u_len_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r3_l2),
        .o_root (w_len)
    );

    assign w_d_in.num  = (r3_pos > r3_neg) ? PROD_W'(r3_pos - r3_neg) : '0;
    assign w_d_in.geom = r3_geom;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly_d[0] <= w_d_in;
            for (int j = 1; j < SQ_LAT; j++) r_dly_d[j] <= r_dly_d[j-1];
        end
    end

    // position quotient, length waits alongside
    logic [ROOT_W-1:0] w_len_den;
    logic [QUO_W-1:0]  w_pquo;
    t_dly_e            w_e_in;
    t_dly_e            r_dly_e [DIV_LAT];

    assign w_len_den = (w_len == '0) ? ROOT_W'(1) : w_len;

    cpseg_div u_pos_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_dly_d[SQ_LAT-1].num),
        .i_den (w_len_den),
        .o_quo (w_pquo)
    );

    assign w_e_in.len  = w_len;
    assign w_e_in.geom = r_dly_d[SQ_LAT-1].geom;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly_e[0] <= w_e_in;
            for (int j = 1; j < DIV_LAT; j++) r_dly_e[j] <= r_dly_e[j-1];
        end
    end

    // clamp position to the segment length
    logic [ROOT_W-1:0] rf_p;
    t_dly_e            rf_e;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rf_e <= r_dly_e[DIV_LAT-1];
            rf_p <= (w_pquo > QUO_W'(r_dly_e[DIV_LAT-1].len)) ?
                    r_dly_e[DIV_LAT-1].len : w_pquo[ROOT_W-1:0];
        end
    end

    // scaled component products
    logic [2:0][PROD_W-1:0] rg_prod;
    logic [ROOT_W-1:0]      rg_len;
    t_dly_h                 rg_h;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rg_len    <= rf_e.len;
            rg_h.p    <= rf_p;
            rg_h.s    <= rf_e.geom.s;
            rg_h.q    <= rf_e.geom.q;
            rg_h.dneg <= rf_e.geom.dneg;
            for (int i = 0; i < 3; i++)
                rg_prod[i] <= PROD_W'(rf_p) * PROD_W'(rf_e.geom.dmag[i]);
        end
    end

    // component offsets along the segment
    logic [ROOT_W-1:0]      w_off_den;
    logic [2:0][QUO_W-1:0]  w_off;
    t_dly_h                 r_dly_h [DIV_LAT];

    assign w_off_den = (rg_len == '0) ? ROOT_W'(1) : rg_len;

    for (genvar i = 0; i < 3; i++) begin : g_off
        cpseg_div u_off_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (rg_prod[i]),
            .i_den (w_off_den),
            .o_quo (w_off[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly_h[0] <= rg_h;
            for (int j = 1; j < DIV_LAT; j++) r_dly_h[j] <= r_dly_h[j-1];
        end
    end

    // nearest point and its gap to the query
    t_dly_h                 w_h;
    logic [2:0][DIFF_W-1:0] w_nr, w_offs;
    t_tail                  ri_tail;
    logic [2:0][DIFF_W-1:0] ri_g;

    assign w_h = r_dly_h[DIV_LAT-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_offs[i] = w_h.dneg[i] ? DIFF_W'(-w_off[i][DIFF_W-1:0]) : w_off[i][DIFF_W-1:0];
            w_nr[i]   = {w_h.s[i][COORD_W-1], w_h.s[i]} + w_offs[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            ri_tail.p <= w_h.p;
            for (int i = 0; i < 3; i++) begin
                ri_tail.nr[i] <= w_nr[i][COORD_W-1:0];
                ri_g[i]       <= {w_h.q[i][COORD_W-1], w_h.q[i]} - w_nr[i];
            end
        end
    end

    // squared gap components
    logic [2:0][DIFF_W-1:0] w_gmag;
    logic [2:0][PROD_W-1:0] rj_gsq;
    t_tail                  rj_tail;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_gmag[i] = ri_g[i][DIFF_W-1] ? DIFF_W'(-ri_g[i]) : ri_g[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rj_tail <= ri_tail;
            for (int i = 0; i < 3; i++)
                rj_gsq[i] <= PROD_W'(w_gmag[i]) * PROD_W'(w_gmag[i]);
        end
    end

    // squared gap sum
    logic [PROD_W-1:0] rk_gsum;
    t_tail             rk_tail;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rk_tail <= rj_tail;
            rk_gsum <= rj_gsq[0] + rj_gsq[1] + rj_gsq[2];
        end
    end

    // gap root, position and point wait alongside
    logic [ROOT_W-1:0] w_gap;
    t_tail             r_dly_l [SQ_LAT];

    cpseg_sqrt u_gap_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (rk_gsum),
        .o_root (w_gap)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly_l[0] <= rk_tail;
            for (int j = 1; j < SQ_LAT; j++) r_dly_l[j] <= r_dly_l[j-1];
        end
    end

    // output register
    logic [OUT_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= {(OUT_W-OUT_RAW)'(0), w_gap,
                      r_dly_l[SQ_LAT-1].nr[2], r_dly_l[SQ_LAT-1].nr[1],
                      r_dly_l[SQ_LAT-1].nr[0], r_dly_l[SQ_LAT-1].p};
        end
    end

    assign o_m_tdata = r_out;

endmodule

### src/cpseg_sqrt.sv
module cpseg_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cpseg_pkg::PROD_W-1:0]  i_rad,
    output logic [cpseg_pkg::ROOT_W-1:0]  o_root
);
    import cpseg_pkg::*;

    logic [SREM_W-1:0] r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [PROD_W-1:0] r_rad  [ROOT_W];

    // one root bit per stage, two radicand bits brought down
    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [SREM_W-1:0] w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [PROD_W-1:0] w_rad;
        logic [SREM_W+1:0] w_t;
        logic [SREM_W+1:0] w_trial;

        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_rad;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_rad  = r_rad[k-1];
        end

        assign w_t     = {w_rem, w_rad[PROD_W-1-2*k -: 2]};
        assign w_trial = {1'b0, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k] <= w_rad;
                if (w_t >= w_trial) begin
                    r_rem[k]  <= SREM_W'(w_t - w_trial);
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_t[SREM_W-1:0];
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

### src/cpseg_div.sv
module cpseg_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cpseg_pkg::PROD_W-1:0]  i_num,
    input  logic [cpseg_pkg::ROOT_W-1:0]  i_den,
    output logic [cpseg_pkg::QUO_W-1:0]   o_quo
);
    import cpseg_pkg::*;

    logic [ROOT_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0]  r_quo [QUO_W];
    logic [PROD_W-1:0] r_num [QUO_W];
    logic [ROOT_W-1:0] r_den [QUO_W];

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [ROOT_W-1:0] w_rem;
        logic [QUO_W-1:0]  w_quo;
        logic [PROD_W-1:0] w_num;
        logic [ROOT_W-1:0] w_den;
        logic [ROOT_W:0]   w_t;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_rem = ROOT_W'(i_num[PROD_W-1:QUO_W]);
            assign w_quo = '0;
            assign w_num = i_num;
            assign w_den = i_den;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_quo = r_quo[k-1];
            assign w_num = r_num[k-1];
            assign w_den = r_den[k-1];
        end

        assign w_t  = {w_rem, w_num[QUO_W-1-k]};
        assign w_ge = (w_t >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= w_num;
                r_den[k] <= w_den;
                r_quo[k] <= {w_quo[QUO_W-2:0], w_ge};
                r_rem[k] <= w_ge ? ROOT_W'(w_t - {1'b0, w_den}) : w_t[ROOT_W-1:0];
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule
